>>> hdl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// shared constants, codes, state type and level conversion for the light
// pattern sequencer
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int STYLES      = 64;
  localparam int PATTERN_LEN = 64;

  localparam int STYLE_W   = 6;
  localparam int POS_W     = 6;
  localparam int LEN_IN_W  = 7;
  localparam int LEN_W     = 6;
  localparam int LETTER_W  = 8;
  localparam int LEVEL_W   = 13;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int OPCODE_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int STORE_AW  = STYLE_W + POS_W;
  localparam int STORE_DEPTH = STYLES * PATTERN_LEN;

  localparam int MOD_BITS_PER_CYCLE = 8;
  localparam int MOD_CYCLES = TIME_W / MOD_BITS_PER_CYCLE;
  localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);
  localparam int DIV_CNT_W  = $clog2(TIME_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
  localparam logic signed [LEVEL_W-1:0] FULL_LEVEL = 13'sd256;

  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SETLEN = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REPORT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LEVEL    = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP,
    S_DIV,
    S_LEN_RD,
    S_LEN,
    S_MOD,
    S_PAT,
    S_WB,
    S_REP_RD,
    S_REP
  } state_t;

  // round((c - 'a') * 256 / 12), never a tie; /3 via reciprocal multiply
  function automatic logic signed [LEVEL_W-1:0] letter_level(input logic [LETTER_W-1:0] c);
    logic signed [14:0] n;
    logic [13:0]        mag;
    logic [30:0]        prod;
    logic [LEVEL_W-1:0] q;
    n    = ($signed({7'd0, c}) - 15'sd97) <<< 6;
    mag  = 14'(n[14] ? (15'sd1 - n) : (n + 15'sd1));
    prod = {17'd0, mag} * 31'd43691;
    q    = 13'(prod >> 17);
    return n[14] ? $signed(13'(~q + 13'd1)) : $signed(q);
  endfunction

endpackage

>>> hdl/light_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// light_pattern_sequencer_top
// per-style brightness patterns in on-chip memories, stepped by time ticks
//
//   channel   direction  handshake          payload
//   in_*      input      in_valid/in_stall  opcode style position letter
//                                           pattern_length time_ms
//   out_*     output     out_valid/out_stall status style_out brightness last
//   cfg_*     input      cfg_wr_en          tick_period (16 bit)
//
// one transaction at a time; set length, write level and unknown opcodes get
// a response, report a level for each style; a tick divides time by the tick
// period in the bit-serial divider, then per style reads the length and, if
// nonzero, takes the step modulo it in the modulo unit and reads that level
// (else full level); an unchanged step answers done; reset and clear sweep the
// pattern store one entry a cycle, taking no transaction; the result register
// lets a finished result wait while the block takes the next transaction
// ----------------------------------------------------------------------------
module light_pattern_sequencer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lps_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [lps_pkg::STYLE_W-1:0]        in_style,
  input  logic [lps_pkg::POS_W-1:0]          in_position,
  input  logic [lps_pkg::LETTER_W-1:0]       in_letter,
  input  logic [lps_pkg::LEN_IN_W-1:0]       in_pattern_length,
  input  logic [lps_pkg::TIME_W-1:0]         in_time_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lps_pkg::STATUS_W-1:0]       out_status,
  output logic [lps_pkg::STYLE_W-1:0]        out_style_out,
  output logic signed [lps_pkg::LEVEL_W-1:0] out_brightness,
  output logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic [lps_pkg::PERIOD_W-1:0]       cfg_wr_data
);
  import lps_pkg::*;

  state_t state_r, state_nxt;

  logic signed [LEVEL_W-1:0] pat_mem [STORE_DEPTH];
  logic [LEN_W-1:0]          len_mem [STYLES];
  logic signed [LEVEL_W-1:0] lev_mem [STYLES];

  logic signed [LEVEL_W-1:0] pat_rd_r;
  logic [LEN_W-1:0]          len_rd_r;
  logic signed [LEVEL_W-1:0] lev_rd_r;

  logic [PERIOD_W-1:0]       tick_period_r;
  logic [TIME_W-1:0]         last_offset_r;
  logic                      offset_valid_r;
  logic [STORE_AW-1:0]       clr_cnt_r;
  logic                      clr_resp_r;
  logic [STATUS_W-1:0]       resp_status_r;
  logic [STYLE_W-1:0]        idx_r;
  logic signed [LEVEL_W-1:0] lvl_r;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [STYLE_W-1:0]        out_style_r;
  logic signed [LEVEL_W-1:0] out_level_r;
  logic                      out_last_r;

  logic                      in_acc;
  logic                      out_free;
  logic                      idx_last;
  logic                      clr_row0;
  logic                      too_long;
  logic [PERIOD_W-1:0]       period_eff;

  logic                      div_start;
  logic                      div_done;
  logic [TIME_W-1:0]         div_quo;
  logic                      mod_start;
  logic                      mod_done;
  logic [LEN_W-1:0]          mod_rem;

  logic                      pat_we;
  logic [STORE_AW-1:0]       pat_waddr;
  logic signed [LEVEL_W-1:0] pat_wdata;
  logic                      len_we;
  logic [STYLE_W-1:0]        len_waddr;
  logic [LEN_W-1:0]          len_wdata;
  logic                      lev_we;
  logic [STYLE_W-1:0]        lev_waddr;
  logic signed [LEVEL_W-1:0] lev_wdata;

  logic                      out_load;
  logic [STATUS_W-1:0]       out_status_nxt;
  logic [STYLE_W-1:0]        out_style_nxt;
  logic signed [LEVEL_W-1:0] out_level_nxt;
  logic                      out_last_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign idx_last   = (idx_r == STYLE_W'(STYLES - 1));
  assign clr_row0   = (clr_cnt_r[STORE_AW-1:POS_W] == '0);
  assign too_long   = (in_pattern_length >= LEN_IN_W'(PATTERN_LEN));
  assign period_eff = (tick_period_r == '0) ? PERIOD_W'(1) : tick_period_r;

  lps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_time_ms),
    .divisor  (period_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  lps_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .value   (last_offset_r),
    .modulus (len_rd_r),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == '1) state_nxt = clr_resp_r ? S_RESP : S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_opcode)
            OP_CLEAR:  state_nxt = S_CLEAR;
            OP_TICK:   state_nxt = S_DIV;
            OP_REPORT: state_nxt = S_REP_RD;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          if (offset_valid_r && div_quo == last_offset_r) state_nxt = S_RESP;
          else state_nxt = S_LEN_RD;
        end
      end
      S_LEN_RD: state_nxt = S_LEN;
      S_LEN: begin
        state_nxt = (len_rd_r == '0) ? S_WB : S_MOD;
      end
      S_MOD: begin
        if (mod_done) state_nxt = S_PAT;
      end
      S_PAT: state_nxt = S_WB;
      S_WB: begin
        if (out_free) state_nxt = idx_last ? S_IDLE : S_LEN_RD;
      end
      S_REP_RD: state_nxt = S_REP;
      S_REP: begin
        if (out_free) state_nxt = idx_last ? S_IDLE : S_REP_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    div_start      = 1'b0;
    mod_start      = 1'b0;
    pat_we         = 1'b0;
    pat_waddr      = clr_cnt_r;
    pat_wdata      = '0;
    len_we         = 1'b0;
    len_waddr      = clr_cnt_r[STYLE_W-1:0];
    len_wdata      = '0;
    lev_we         = 1'b0;
    lev_waddr      = clr_cnt_r[STYLE_W-1:0];
    lev_wdata      = '0;
    out_load       = 1'b0;
    out_status_nxt = ST_DONE;
    out_style_nxt  = '0;
    out_level_nxt  = '0;
    out_last_nxt   = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        pat_we = 1'b1;
        len_we = clr_row0;
        lev_we = clr_row0;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_opcode)
            OP_SETLEN: begin
              len_we    = !too_long;
              len_waddr = in_style;
              len_wdata = in_pattern_length[LEN_W-1:0];
            end
            OP_WRITE: begin
              pat_we    = 1'b1;
              pat_waddr = {in_style, in_position};
              pat_wdata = letter_level(in_letter);
            end
            OP_TICK: div_start = 1'b1;
            default: ;
          endcase
        end
      end
      S_RESP: begin
        out_load       = out_free;
        out_status_nxt = resp_status_r;
      end
      S_LEN: begin
        mod_start = (len_rd_r != '0);
      end
      S_WB: begin
        lev_we         = out_free;
        lev_waddr      = idx_r;
        lev_wdata      = lvl_r;
        out_load       = out_free;
        out_status_nxt = ST_LEVEL;
        out_style_nxt  = idx_r;
        out_level_nxt  = lvl_r;
        out_last_nxt   = idx_last;
      end
      S_REP: begin
        out_load       = out_free;
        out_status_nxt = ST_LEVEL;
        out_style_nxt  = idx_r;
        out_level_nxt  = lev_rd_r;
        out_last_nxt   = idx_last;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_waddr] <= pat_wdata;
    pat_rd_r <= pat_mem[{idx_r, mod_rem}];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rd_r <= len_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (lev_we) lev_mem[lev_waddr] <= lev_wdata;
    lev_rd_r <= lev_mem[idx_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      clr_resp_r     <= 1'b0;
      offset_valid_r <= 1'b0;
      tick_period_r  <= PERIOD_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) tick_period_r <= cfg_wr_data;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (in_acc && in_opcode == OP_CLEAR) begin
        clr_cnt_r      <= '0;
        clr_resp_r     <= 1'b1;
        offset_valid_r <= 1'b0;
      end
      if (state_r == S_DIV && state_nxt == S_LEN_RD) offset_valid_r <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r         <= '0;
      resp_status_r <= (in_opcode == OP_SETLEN && too_long) ? ST_TOO_LONG : ST_DONE;
    end else if ((state_r == S_WB || state_r == S_REP) && out_free) begin
      idx_r <= idx_r + 1'b1;
    end
    if (state_r == S_DIV && div_done) last_offset_r <= div_quo;
    if (state_r == S_LEN) lvl_r <= FULL_LEVEL;
    else if (state_r == S_PAT) lvl_r <= pat_rd_r;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_style_r  <= out_style_nxt;
      out_level_r  <= out_level_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_style_out  = out_style_r;
  assign out_brightness = out_level_r;
  assign out_last       = out_last_r;

endmodule

>>> hdl/lps_div.sv
// ----------------------------------------------------------------------------
// lps_div
// restoring divider, one quotient bit per cycle, time over tick period
// ----------------------------------------------------------------------------
module lps_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lps_pkg::TIME_W-1:0]    dividend,
  input  logic [lps_pkg::PERIOD_W-1:0]  divisor,
  output logic                          done,
  output logic [lps_pkg::TIME_W-1:0]    quotient
);
  import lps_pkg::*;

  logic [PERIOD_W-1:0]  rem_r;
  logic [PERIOD_W-1:0]  rem_nxt;
  logic [PERIOD_W-1:0]  div_r;
  logic [TIME_W-1:0]    quo_r;
  logic [TIME_W-1:0]    quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [PERIOD_W:0]    trial;

  always_comb begin
    trial = {rem_r, quo_r[TIME_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = PERIOD_W'(trial - {1'b0, div_r});
      quo_nxt = {quo_r[TIME_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[PERIOD_W-1:0];
      quo_nxt = {quo_r[TIME_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(TIME_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/lps_mod.sv
// ----------------------------------------------------------------------------
// lps_mod
// step offset modulo pattern length, eight remainder steps per cycle
// ----------------------------------------------------------------------------
module lps_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lps_pkg::TIME_W-1:0]  value,
  input  logic [lps_pkg::LEN_W-1:0]   modulus,
  output logic                        done,
  output logic [lps_pkg::LEN_W-1:0]   rem
);
  import lps_pkg::*;

  logic [LEN_W-1:0]     rem_r;
  logic [LEN_W-1:0]     rem_nxt;
  logic [LEN_W-1:0]     mod_r;
  logic [TIME_W-1:0]    val_r;
  logic [TIME_W-1:0]    val_nxt;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  always_comb begin
    logic [LEN_W:0] trial;
    rem_nxt = rem_r;
    val_nxt = val_r;
    for (int k = 0; k < MOD_BITS_PER_CYCLE; k++) begin
      trial   = {rem_nxt, val_nxt[TIME_W-1]};
      val_nxt = {val_nxt[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, mod_r}) begin
        rem_nxt = LEN_W'(trial - {1'b0, mod_r});
      end else begin
        rem_nxt = trial[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      mod_r <= modulus;
      val_r <= value;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      val_r <= val_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
